FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hw/rtl/fpl_pkg.sv
// ---------------------------------------------------------------------------
// fpl_pkg
// Constants, state type and log2/exp2 tables for the peak limiter.
// ---------------------------------------------------------------------------
package fpl_pkg;

    localparam int LOG_TABLE_BITS = 6;
    localparam int TAB_N          = 1 << LOG_TABLE_BITS;
    localparam int LOG_SH         = 23 - LOG_TABLE_BITS;
    localparam int EXP_SH         = 16 - LOG_TABLE_BITS;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_ATTACK    = 3'd1;
    localparam logic [2:0] REG_RELEASE   = 3'd2;
    localparam logic [2:0] REG_SLOPE     = 3'd3;
    localparam logic [2:0] REG_HEADROOM  = 3'd4;

    localparam logic [23:0] THRESHOLD_RST = 24'd4194304;
    localparam logic [23:0] ATTACK_RST    = 24'd16431500;
    localparam logic [23:0] RELEASE_RST   = 24'd16773721;
    localparam logic [15:0] SLOPE_RST     = 16'd65535;
    localparam logic [16:0] HEADROOM_RST  = 17'd65536;
    localparam logic [16:0] HEADROOM_MIN  = 17'd6554;
    localparam logic [16:0] HEADROOM_MAX  = 17'd65536;
    localparam logic [23:0] UNITY_GAIN    = 24'd8388608;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_A, ST_MUL_B, ST_ENV, ST_NORM, ST_LOG, ST_LOG_ACC,
        ST_SLOPE, ST_EXPI, ST_GAIN, ST_MAG_G, ST_HLO, ST_HHI, ST_FIN
    } state_t;

    typedef logic [31:0] tab_t [0:TAB_N];

    function automatic logic [63:0] frac_log2(input logic [63:0] m_in);
        logic [63:0] m;
        logic [63:0] res;
        m   = m_in;
        res = 64'd0;
        for (int k = 0; k < 16; k++)
        begin
            m   = (m * m) >> 30;
            res = res << 1;
            if (m >= (64'd1 << 31))
            begin
                res = res | 64'd1;
                m   = m >> 1;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic tab_t build_log();
        tab_t t;
        for (int i = 0; i < TAB_N; i++)
        begin
            t[i] = 32'(frac_log2((64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS))));
        end
        t[TAB_N] = 32'd65536;
        return t;
    endfunction

    function automatic tab_t build_exp();
        tab_t t;
        logic [63:0] root [0:LOG_TABLE_BITS];
        logic [63:0] e;
        root[0] = 64'd1 << 31;
        for (int k = 1; k <= LOG_TABLE_BITS; k++)
        begin
            root[k] = isqrt64(root[k-1] << 30);
        end
        for (int i = 0; i < TAB_N; i++)
        begin
            e = 64'd1 << 30;
            for (int k = 1; k <= LOG_TABLE_BITS; k++)
            begin
                if (((i >> (LOG_TABLE_BITS - k)) & 1) != 0)
                begin
                    e = (e * root[k]) >> 30;
                end
            end
            t[i] = 32'(e);
        end
        t[TAB_N] = 32'h8000_0000;
        return t;
    endfunction

    localparam tab_t LOG_TAB = build_log();
    localparam tab_t EXP_TAB = build_exp();

endpackage

FILE: hw/rtl/fpl_in_if.sv
// ---------------------------------------------------------------------------
// fpl_in_if
// Sample request channel into the limiter.
// ---------------------------------------------------------------------------
interface fpl_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_in;
    logic               last_in_block;

    modport source (output valid, output sample_in, output last_in_block, input ready);
    modport sink   (input valid, input sample_in, input last_in_block, output ready);
endinterface

FILE: hw/rtl/fpl_out_if.sv
// ---------------------------------------------------------------------------
// fpl_out_if
// Result request channel out of the limiter.
// ---------------------------------------------------------------------------
interface fpl_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_out;
    logic               reducing;

    modport source (output valid, output sample_out, output reducing, input ready);
    modport sink   (input valid, input sample_out, input reducing, output ready);
endinterface

FILE: hw/rtl/feedforward_peak_limiter_top.sv
// ---------------------------------------------------------------------------
// feedforward_peak_limiter_top
// Feedforward peak limiter with attack/release envelope and log-domain gain.
// ---------------------------------------------------------------------------
// When the envelope is at or below threshold, unity gain is applied and a sample
// goes from the envelope multiplies and update straight to the output multiplies.
// With gain reduction it also takes the log, slope and exp steps. The
// envelope and threshold are each normalised by a one-bit-per-cycle shifter,
// and every product goes through a single shared 25x25
// multiplier with a registered output. A new sample is taken only in idle; a
// finished result waits in the output register while the next sample is taken,
// and a held output stalls the following sample in its last cycle.
`include "assert_macros.svh"

module feedforward_peak_limiter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    fpl_in_if.sink      din,
    fpl_out_if.source   dout
);

    fpl_pkg::state_t state_reg, state_next;

    logic [23:0] threshold_reg, attack_reg, release_reg;
    logic [15:0] slope_reg;
    logic [16:0] headroom_reg;
    logic [23:0] envelope_reg, envelope_next;

    logic        neg_reg, neg_next;
    logic        last_reg, last_next;
    logic [24:0] mag_reg, mag_next;
    logic [23:0] c_reg, c_next;
    logic [47:0] acc_reg, acc_next;
    logic [49:0] prod_reg;
    logic [23:0] x_reg, x_next;
    logic [4:0]  p_reg, p_next;
    logic        sel_reg, sel_next;
    logic [31:0] lo_reg, lo_next;
    logic [20:0] le_reg, le_next;
    logic [20:0] d_reg, d_next;
    logic [4:0]  rint_reg, rint_next;
    logic [23:0] gain_reg, gain_next;
    logic        red_reg, red_next;
    logic [22:0] pghi_reg, pghi_next;

    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;
    logic        out_red_reg, out_red_next;

    logic [24:0] mul_a, mul_b;
    logic [23:0] thr;
    logic [16:0] h;

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign thr = (threshold_reg == 24'd0) ? 24'd1 : threshold_reg;
    assign h   = (headroom_reg < fpl_pkg::HEADROOM_MIN) ? fpl_pkg::HEADROOM_MIN :
                 (headroom_reg > fpl_pkg::HEADROOM_MAX) ? fpl_pkg::HEADROOM_MAX :
                 headroom_reg;

    assign din.ready       = (state_reg == fpl_pkg::ST_IDLE);
    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_data_reg;
    assign dout.reducing   = out_red_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= fpl_pkg::THRESHOLD_RST;
            attack_reg    <= fpl_pkg::ATTACK_RST;
            release_reg   <= fpl_pkg::RELEASE_RST;
            slope_reg     <= fpl_pkg::SLOPE_RST;
            headroom_reg  <= fpl_pkg::HEADROOM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fpl_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                fpl_pkg::REG_ATTACK:    attack_reg    <= cfg_data;
                fpl_pkg::REG_RELEASE:   release_reg   <= cfg_data;
                fpl_pkg::REG_SLOPE:     slope_reg     <= cfg_data[15:0];
                fpl_pkg::REG_HEADROOM:  headroom_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpl_pkg::ST_IDLE;
            envelope_reg  <= 24'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            envelope_reg  <= envelope_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        last_reg     <= last_next;
        mag_reg      <= mag_next;
        c_reg        <= c_next;
        acc_reg      <= acc_next;
        x_reg        <= x_next;
        p_reg        <= p_next;
        sel_reg      <= sel_next;
        lo_reg       <= lo_next;
        le_reg       <= le_next;
        d_reg        <= d_next;
        rint_reg     <= rint_next;
        gain_reg     <= gain_next;
        red_reg      <= red_next;
        pghi_reg     <= pghi_next;
        out_data_reg <= out_data_next;
        out_red_reg  <= out_red_next;
    end

    always_comb
    begin
        logic [24:0] mag_in;
        logic [48:0] env_sum;
        logic [23:0] env;
        logic [fpl_pkg::LOG_TABLE_BITS-1:0] lidx;
        logic [31:0] llo, lhi, ldiff;
        logic [20:0] lval;
        logic [20:0] rval;
        logic [16:0] u;
        logic [16-fpl_pkg::EXP_SH:0] eidx;
        logic [31:0] elo, ehi, ediff;
        logic [31:0] e;
        logic [5:0]  sft;
        logic [32:0] rnd, g;
        logic [63:0] total;
        logic [24:0] q;
        logic [23:0] lim;

        state_next     = state_reg;
        envelope_next  = envelope_reg;
        neg_next       = neg_reg;
        last_next      = last_reg;
        mag_next       = mag_reg;
        c_next         = c_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        sel_next       = sel_reg;
        lo_next        = lo_reg;
        le_next        = le_reg;
        d_next         = d_reg;
        rint_next      = rint_reg;
        gain_next      = gain_reg;
        red_next       = red_reg;
        pghi_next      = pghi_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        out_data_next  = out_data_reg;
        out_red_next   = out_red_reg;
        mul_a          = 25'd0;
        mul_b          = 25'd0;

        mag_in  = din.sample_in[23] ? (25'd16777216 - {1'b0, din.sample_in}) :
                  {1'b0, din.sample_in};
        env_sum = 49'(acc_reg) + 49'(prod_reg[47:0]) + 49'd8388608;
        env     = env_sum[47:24];
        lidx    = x_reg[22 -: fpl_pkg::LOG_TABLE_BITS];
        llo     = fpl_pkg::LOG_TAB[lidx];
        lhi     = fpl_pkg::LOG_TAB[32'(lidx) + 1];
        ldiff   = (lhi > llo) ? (lhi - llo) : 32'd0;
        lval    = 21'({p_reg, 16'd0}) + 21'(lo_reg) + 21'(prod_reg[49:fpl_pkg::LOG_SH]);
        rval    = 21'((prod_reg[36:0] + 37'd32768) >> 16);
        u       = 17'd65536 - {1'b0, rval[15:0]};
        eidx    = u[16:fpl_pkg::EXP_SH];
        if (eidx >= (16 - fpl_pkg::EXP_SH + 1)'(fpl_pkg::TAB_N))
        begin
            elo   = fpl_pkg::EXP_TAB[fpl_pkg::TAB_N];
            ediff = 32'd0;
        end
        else
        begin
            elo   = fpl_pkg::EXP_TAB[eidx[fpl_pkg::LOG_TABLE_BITS-1:0]];
            ehi   = fpl_pkg::EXP_TAB[32'(eidx) + 1];
            ediff = (ehi > elo) ? (ehi - elo) : 32'd0;
        end
        ehi     = 32'd0;
        e       = lo_reg + 32'(prod_reg[49:fpl_pkg::EXP_SH]);
        sft     = 6'd8 + {1'b0, rint_reg};
        rnd     = 33'd1 << (sft - 6'd1);
        g       = ({1'b0, e} + rnd) >> sft;
        total   = (64'(prod_reg[40:0]) << 24) + 64'(acc_reg[40:0]) + (64'd1 << 38);
        q       = total[63:39];
        lim     = {h, 7'd0};

        unique case (state_reg)
            fpl_pkg::ST_IDLE:
            begin
                if (din.valid)
                begin
                    neg_next   = din.sample_in[23];
                    last_next  = din.last_in_block;
                    mag_next   = mag_in;
                    c_next     = (mag_in > {1'b0, envelope_reg}) ? attack_reg : release_reg;
                    state_next = fpl_pkg::ST_MUL_A;
                end
            end
            fpl_pkg::ST_MUL_A:
            begin
                mul_a      = {1'b0, c_reg};
                mul_b      = {1'b0, envelope_reg};
                state_next = fpl_pkg::ST_MUL_B;
            end
            fpl_pkg::ST_MUL_B:
            begin
                mul_a      = 25'd16777216 - {1'b0, c_reg};
                mul_b      = mag_reg;
                acc_next   = prod_reg[47:0];
                state_next = fpl_pkg::ST_ENV;
            end
            fpl_pkg::ST_ENV:
            begin
                envelope_next = last_reg ? 24'd0 : env;
                if (env > thr)
                begin
                    x_next     = env;
                    p_next     = 5'd23;
                    sel_next   = 1'b0;
                    state_next = fpl_pkg::ST_NORM;
                end
                else
                begin
                    gain_next  = fpl_pkg::UNITY_GAIN;
                    red_next   = 1'b0;
                    state_next = fpl_pkg::ST_MAG_G;
                end
            end
            fpl_pkg::ST_NORM:
            begin
                if (x_reg[23] || (p_reg == 5'd0))
                begin
                    state_next = fpl_pkg::ST_LOG;
                end
                else
                begin
                    x_next = {x_reg[22:0], 1'b0};
                    p_next = p_reg - 5'd1;
                end
            end
            fpl_pkg::ST_LOG:
            begin
                mul_a      = 25'(ldiff);
                mul_b      = 25'(x_reg[fpl_pkg::LOG_SH-1:0]);
                lo_next    = llo;
                state_next = fpl_pkg::ST_LOG_ACC;
            end
            fpl_pkg::ST_LOG_ACC:
            begin
                if (!sel_reg)
                begin
                    le_next    = lval;
                    x_next     = thr;
                    p_next     = 5'd23;
                    sel_next   = 1'b1;
                    state_next = fpl_pkg::ST_NORM;
                end
                else
                begin
                    d_next     = (le_reg > lval) ? (le_reg - lval) : 21'd0;
                    state_next = fpl_pkg::ST_SLOPE;
                end
            end
            fpl_pkg::ST_SLOPE:
            begin
                mul_a      = {4'd0, d_reg};
                mul_b      = {9'd0, slope_reg};
                state_next = fpl_pkg::ST_EXPI;
            end
            fpl_pkg::ST_EXPI:
            begin
                mul_a      = 25'(ediff);
                mul_b      = 25'(u[fpl_pkg::EXP_SH-1:0]);
                lo_next    = elo;
                rint_next  = rval[20:16];
                state_next = fpl_pkg::ST_GAIN;
            end
            fpl_pkg::ST_GAIN:
            begin
                gain_next  = (sft >= 6'd40) ? 24'd0 : g[23:0];
                red_next   = ((sft >= 6'd40) ? 24'd0 : g[23:0]) < fpl_pkg::UNITY_GAIN;
                state_next = fpl_pkg::ST_MAG_G;
            end
            fpl_pkg::ST_MAG_G:
            begin
                mul_a      = mag_reg;
                mul_b      = {1'b0, gain_reg};
                state_next = fpl_pkg::ST_HLO;
            end
            fpl_pkg::ST_HLO:
            begin
                mul_a      = {1'b0, prod_reg[23:0]};
                mul_b      = {8'd0, h};
                pghi_next  = prod_reg[46:24];
                state_next = fpl_pkg::ST_HHI;
            end
            fpl_pkg::ST_HHI:
            begin
                mul_a      = {2'd0, pghi_reg};
                mul_b      = {8'd0, h};
                acc_next   = prod_reg[47:0];
                state_next = fpl_pkg::ST_FIN;
            end
            fpl_pkg::ST_FIN:
            begin
                // keep the high partial product in place while the output is held
                mul_a      = {2'd0, pghi_reg};
                mul_b      = {8'd0, h};
                if (!out_valid_reg || dout.ready)
                begin
                    if (q > {1'b0, lim})
                    begin
                        q = {1'b0, lim};
                    end
                    if (neg_reg)
                    begin
                        out_data_next = 24'd0 - q[23:0];
                    end
                    else
                    begin
                        out_data_next = (q > 25'h7FFFFF) ? 24'h7FFFFF : q[23:0];
                    end
                    out_red_next   = red_reg;
                    out_valid_next = 1'b1;
                    state_next     = fpl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpl_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEVER(a_env_range, envelope_reg > fpl_pkg::UNITY_GAIN, "envelope above full scale")
    `ASSERT_NEVER(a_gain_range, (state_reg == fpl_pkg::ST_MAG_G) && (gain_reg > fpl_pkg::UNITY_GAIN), "gain above unity")
    `ASSERT_PROP(a_accept_start, (din.valid && din.ready) |=> (state_reg == fpl_pkg::ST_MUL_A), "accepted request did not start")
    `ASSERT_PROP(a_red_gain, ((state_reg == fpl_pkg::ST_MAG_G) && red_reg) |-> (gain_reg < fpl_pkg::UNITY_GAIN), "reducing flag without gain below one")

endmodule
